// ----- design/mcpg_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the midpoint circle point generator
// no dependencies; imported by every module of the block

package mcpg_pkg;

	localparam int COORD_BITS  = 11;
	localparam int RADIUS_BITS = 10;
	localparam int DEC_BITS    = 18;
	localparam int PT_BITS     = COORD_BITS + 1;

	// one group is eight points
	localparam int IDX_BITS = 3;
	localparam logic [IDX_BITS-1:0] PT_FIRST = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] PT_LAST  = IDX_BITS'(7);

	// group queue between front and back
	localparam int QDEPTH     = 2;
	localparam int QPTR_BITS  = 1;
	localparam int QCNT_BITS  = 2;

	typedef enum logic {
		REQ_START   = 1'b0,
		REQ_ADVANCE = 1'b1
	} req_type_t;

	// one group of eight points waiting to be emitted
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic        [COORD_BITS-1:0] sx;
		logic        [COORD_BITS-1:0] sy;
		logic                         done;
	} grp_desc_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic head_valid;
	} grp_q_stat_t;

endpackage

// ----- design/mcpg_front.sv -----
`timescale 1ns / 1ps
// front part: accepts start/advance items, runs the midpoint step, queues groups
// depends on mcpg_pkg

module mcpg_front import mcpg_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	input  grp_q_stat_t                   q_stat,
	output logic                          push,
	output grp_desc_t                     push_desc
);

	logic        [COORD_BITS-1:0]  step_x_q;
	logic        [COORD_BITS-1:0]  step_y_q;
	logic        [DEC_BITS-1:0]    decision_q;
	logic signed [COORD_BITS-1:0]  held_cx_q;
	logic signed [COORD_BITS-1:0]  held_cy_q;
	logic                          active_q;

	logic                  accept;
	logic                  is_start;
	logic [COORD_BITS-1:0] nx;
	logic [COORD_BITS-1:0] ny;
	logic [DEC_BITS-1:0]   ndec;
	logic [DEC_BITS-1:0]   x8;
	logic [DEC_BITS-1:0]   y8;

	assign req_stall = q_stat.full;
	assign accept    = req_valid && !req_stall;
	assign is_start  = (req_type_t'(req_type) == REQ_START);

	always_comb begin
		x8 = DEC_BITS'(step_x_q) << 3;
		y8 = DEC_BITS'(step_y_q) << 3;
		if (is_start) begin
			nx   = '0;
			ny   = COORD_BITS'(radius);
			ndec = DEC_BITS'(5) - (DEC_BITS'(radius) << 2);
		end else if (decision_q[DEC_BITS-1]) begin
			// decision below zero: step x only
			nx   = step_x_q + COORD_BITS'(1);
			ny   = step_y_q;
			ndec = decision_q + x8 + DEC_BITS'(12);
		end else begin
			nx   = step_x_q + COORD_BITS'(1);
			ny   = step_y_q - COORD_BITS'(1);
			ndec = decision_q + x8 - y8 + DEC_BITS'(20);
		end
	end

	assign push           = accept && (is_start || active_q);
	assign push_desc.cx   = is_start ? center_x : held_cx_q;
	assign push_desc.cy   = is_start ? center_y : held_cy_q;
	assign push_desc.sx   = nx;
	assign push_desc.sy   = ny;
	assign push_desc.done = !(nx < ny);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			active_q   <= 1'b0;
		end else if (push) begin
			step_x_q   <= nx;
			step_y_q   <= ny;
			decision_q <= ndec;
			held_cx_q  <= push_desc.cx;
			held_cy_q  <= push_desc.cy;
			active_q   <= (nx < ny);
		end
	end

endmodule

// ----- design/mcpg_queue.sv -----
`timescale 1ns / 1ps
// short queue of point groups between front and back
// depends on mcpg_pkg

module mcpg_queue import mcpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  grp_desc_t   push_desc,
	input  logic        pop,
	output grp_desc_t   head,
	output grp_q_stat_t stat
);

	grp_desc_t             entry_q [QDEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;

	assign head            = entry_q[rd_ptr_q];
	assign stat.full       = (count_q == QCNT_BITS'(QDEPTH));
	assign stat.head_valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QDEPTH))
		else $error("group queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q == rd_ptr_q + count_q[QPTR_BITS-1:0])
		else $error("group queue pointers disagree with count");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty group queue");

endmodule

// ----- design/mcpg_back.sv -----
`timescale 1ns / 1ps
// back part: emits the eight symmetric points of each queued group,
// one per cycle while point_stall is low; depends on mcpg_pkg

module mcpg_back import mcpg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grp_desc_t                  head,
	input  grp_q_stat_t                q_stat,
	output logic                       pop,
	output logic                       point_valid,
	input  logic                       point_stall,
	output logic signed [PT_BITS-1:0]  point_x,
	output logic signed [PT_BITS-1:0]  point_y,
	output logic                       group_last,
	output logic                       circle_done
);

	grp_desc_t                  cur_q;
	logic [IDX_BITS-1:0]        idx_q;
	logic                       out_valid_q;
	logic signed [PT_BITS-1:0]  point_x_q;
	logic signed [PT_BITS-1:0]  point_y_q;
	logic                       group_last_q;
	logic                       circle_done_q;

	grp_desc_t                  src;
	logic                       adv;
	logic                       can_issue;
	logic                       load;
	logic                       swap;
	logic                       neg_x;
	logic                       neg_y;
	logic [COORD_BITS-1:0]      mag_x;
	logic [COORD_BITS-1:0]      mag_y;
	logic signed [PT_BITS-1:0]  off_x;
	logic signed [PT_BITS-1:0]  off_y;
	logic signed [PT_BITS-1:0]  px;
	logic signed [PT_BITS-1:0]  py;

	// first point of a group comes straight from the queue head
	assign src       = (idx_q == PT_FIRST) ? head : cur_q;
	assign adv       = !out_valid_q || !point_stall;
	assign can_issue = (idx_q != PT_FIRST) || q_stat.head_valid;
	assign load      = adv && can_issue;
	assign pop       = load && (idx_q == PT_FIRST);

	// order: (x,y) (y,x) (-y,x) (-x,y) (-x,-y) (-y,-x) (y,-x) (x,-y)
	always_comb begin
		case (idx_q)
			3'd1, 3'd2, 3'd5, 3'd6: swap = 1'b1;
			default:                swap = 1'b0;
		endcase
		case (idx_q)
			3'd2, 3'd3, 3'd4, 3'd5: neg_x = 1'b1;
			default:                neg_x = 1'b0;
		endcase
		case (idx_q)
			3'd4, 3'd5, 3'd6, 3'd7: neg_y = 1'b1;
			default:                neg_y = 1'b0;
		endcase
		mag_x = swap ? src.sy : src.sx;
		mag_y = swap ? src.sx : src.sy;
		off_x = signed'({1'b0, mag_x});
		off_y = signed'({1'b0, mag_y});
		px    = PT_BITS'(src.cx) + (neg_x ? -off_x : off_x);
		py    = PT_BITS'(src.cy) + (neg_y ? -off_y : off_y);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load) begin
			point_x_q     <= px;
			point_y_q     <= py;
			group_last_q  <= (idx_q == PT_LAST);
			circle_done_q <= src.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= PT_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= can_issue;
			end
			if (load) begin
				idx_q <= idx_q + IDX_BITS'(1);
			end
		end
	end

	assign point_valid = out_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign group_last  = group_last_q;
	assign circle_done = circle_done_q;

	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (group_last_q == (idx_q == PT_FIRST)))
		else $error("group_last out of step with point index");

endmodule

// ----- design/midpoint_circle_point_generator.sv -----
`timescale 1ns / 1ps
// Midpoint circle point generator, eight-way symmetry, decision value scaled by four.
// Request channel: req_valid/req_stall with req_type (start or advance), center, radius.
// A start loads center and radius and yields the eight points of (0, r); each advance
// runs one midpoint step and yields eight more points; an advance with no circle in
// progress yields nothing. Point channel: point_valid/point_stall with point_x, point_y,
// group_last on the eighth point of a group and circle_done on every point of the final
// group. The first point of a group passes through the group queue and then the point
// register before it is valid. Throughput: one point per cycle while point_stall is low,
// set by the eight points of a group leaving one at a time on the single point channel;
// advances that yield nothing push no group into the queue.
// A two-entry group queue parts the front from the back, so the front keeps
// taking items while points still drain. When point_stall is high the point register
// holds, the queue fills, and req_stall rises once it is full. Reset clears the circle
// state (no circle in progress), empties the queue and drops point_valid.
// depends on mcpg_pkg, mcpg_front, mcpg_queue, mcpg_back

module midpoint_circle_point_generator import mcpg_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	output logic                          point_valid,
	input  logic                          point_stall,
	output logic signed [PT_BITS-1:0]     point_x,
	output logic signed [PT_BITS-1:0]     point_y,
	output logic                          group_last,
	output logic                          circle_done
);

	grp_q_stat_t q_stat;
	grp_desc_t   push_desc;
	grp_desc_t   head;
	logic        push;
	logic        pop;

	mcpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	mcpg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	mcpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

endmodule

// ----- bench/mcpg_checker.sv -----
`timescale 1ns / 1ps
// checker for the midpoint circle point generator: watches both channels,
// predicts the eight points of every request that yields a group and compares them in order
// depends on mcpg_pkg

module mcpg_checker import mcpg_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic                          req_type,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	input  logic                          point_valid,
	input  logic                          point_stall,
	input  logic signed [PT_BITS-1:0]     point_x,
	input  logic signed [PT_BITS-1:0]     point_y,
	input  logic                          group_last,
	input  logic                          circle_done,
	output int                            fails,
	output int                            points_due
);

	typedef struct {
		logic signed [PT_BITS-1:0] px;
		logic signed [PT_BITS-1:0] py;
		logic                      last;
		logic                      done;
	} pixel_t;

	pixel_t expected_points[$];

	// circle state as the block should hold it
	int                           arc_x;
	int                           arc_y;
	logic signed [DEC_BITS-1:0]   midpoint_dec;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic                         drawing;
	int                           points_seen;

	initial begin
		fails = 0;
		points_due = 0;
		points_seen = 0;
	end

	// eight symmetric points of (arc_x, arc_y) around the held center
	function automatic void queue_octants(input logic final_group);
		pixel_t p;
		int     dx;
		int     dy;
		for (int k = 0; k < 8; k++) begin
			case (k)
				0: begin dx = arc_x;  dy = arc_y;  end
				1: begin dx = arc_y;  dy = arc_x;  end
				2: begin dx = -arc_y; dy = arc_x;  end
				3: begin dx = -arc_x; dy = arc_y;  end
				4: begin dx = -arc_x; dy = -arc_y; end
				5: begin dx = -arc_y; dy = -arc_x; end
				6: begin dx = arc_y;  dy = -arc_x; end
				default: begin dx = arc_x; dy = -arc_y; end
			endcase
			p.px = PT_BITS'(int'(origin_x) + dx);
			p.py = PT_BITS'(int'(origin_y) + dy);
			p.last = (k == 7);
			p.done = final_group;
			expected_points.push_back(p);
		end
	endfunction

	function automatic void take_request();
		int next_dec;
		if (req_type == REQ_START) begin
			origin_x = center_x;
			origin_y = center_y;
			arc_x = 0;
			arc_y = int'(radius);
			next_dec = 5 - 4 * int'(radius);
			midpoint_dec = next_dec[DEC_BITS-1:0];
			drawing = (arc_x < arc_y);
			queue_octants(!drawing);
		end else if (drawing) begin
			// midpoint step from the old x and y
			if (midpoint_dec < 0) begin
				next_dec = int'(midpoint_dec) + 4 * (2 * arc_x + 3);
				arc_x++;
			end else begin
				next_dec = int'(midpoint_dec) + 4 * (2 * arc_x - 2 * arc_y + 5);
				arc_x++;
				arc_y--;
			end
			midpoint_dec = next_dec[DEC_BITS-1:0];
			drawing = (arc_x < arc_y);
			queue_octants(!drawing);
		end
	endfunction

	function automatic void check_point();
		pixel_t want;
		if (expected_points.size() == 0) begin
			$display("%0t: unexpected point x %0d y %0d last %0b done %0b", $time,
				point_x, point_y, group_last, circle_done);
			fails++;
			return;
		end
		want = expected_points.pop_front();
		if (point_x !== want.px) begin
			$display("%0t: point %0d point_x expected %0d actual %0d", $time,
				points_seen, want.px, point_x);
			fails++;
		end
		if (point_y !== want.py) begin
			$display("%0t: point %0d point_y expected %0d actual %0d", $time,
				points_seen, want.py, point_y);
			fails++;
		end
		if (group_last !== want.last) begin
			$display("%0t: point %0d group_last expected %0b actual %0b", $time,
				points_seen, want.last, group_last);
			fails++;
		end
		if (circle_done !== want.done) begin
			$display("%0t: point %0d circle_done expected %0b actual %0b", $time,
				points_seen, want.done, circle_done);
			fails++;
		end
		points_seen++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_x = 0;
			arc_y = 0;
			midpoint_dec = '0;
			origin_x = '0;
			origin_y = '0;
			drawing = 1'b0;
			expected_points.delete();
		end else begin
			if (point_valid && !point_stall)
				check_point();
			if (req_valid && !req_stall)
				take_request();
		end
		points_due = expected_points.size();
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for the midpoint circle point generator: clock, reset, request
// stimulus, point-side stalls, watchdog and verdict
// depends on mcpg_pkg, midpoint_circle_point_generator and mcpg_checker

module tb_top;
	import mcpg_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int TAIL_CYCLES = 10;
	localparam int ITEM_GOAL   = 470;
	localparam int CALM_AFTER  = 420;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic                          req_type;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;
	logic                          point_valid;
	logic                          point_stall;
	logic signed [PT_BITS-1:0]     point_x;
	logic signed [PT_BITS-1:0]     point_y;
	logic                          group_last;
	logic                          circle_done;

	int   fail_count;
	int   points_due;
	int   reqs_sent;
	int   quiet_cycles;
	int   gap_odds;
	logic calm;

	midpoint_circle_point_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

	mcpg_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.group_last  (group_last),
		.circle_done (circle_done),
		.fails       (fail_count),
		.points_due  (points_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_req(input logic kind, input logic signed [COORD_BITS-1:0] cx,
			input logic signed [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_valid = 1'b1;
		req_type = kind;
		center_x = cx;
		center_y = cy;
		radius = r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		reqs_sent++;
	endtask

	task automatic start_circle(input logic signed [COORD_BITS-1:0] cx,
			input logic signed [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r);
		offer_req(REQ_START, cx, cy, r);
	endtask

	// advance fields carry junk, the block must ignore them
	task automatic step_circle(input int n);
		for (int i = 0; i < n; i++)
			offer_req(REQ_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
				RADIUS_BITS'($urandom));
	endtask

	task automatic drain_points();
		req_valid = 1'b0;
		while (points_due != 0) @(negedge clk);
	endtask

	function automatic logic signed [COORD_BITS-1:0] pick_center();
		case ($urandom_range(0, 9))
			0: pick_center = {1'b1, {(COORD_BITS-1){1'b0}}};
			1: pick_center = {1'b0, {(COORD_BITS-1){1'b1}}};
			default: pick_center = COORD_BITS'($urandom);
		endcase
	endfunction

	// point-side stalls: bursts, with stretches of none
	initial begin
		point_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				point_stall = 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				point_stall = 1'b0;
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(30, 80)) @(negedge clk);
			else
				repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (point_valid && !point_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int                    sel;
		int                    n;
		logic [RADIUS_BITS-1:0] r;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_START;
		center_x = '0;
		center_y = '0;
		radius = '0;
		reqs_sent = 0;
		quiet_cycles = 0;
		gap_odds = 3;
		calm = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle advance, zero radius, extremes, both decision branches,
		// advance after the end, restart in the middle of a circle
		step_circle(1);
		start_circle(COORD_BITS'(0), COORD_BITS'(0), RADIUS_BITS'(0));
		step_circle(1);
		start_circle(COORD_BITS'(-1024), COORD_BITS'(1023), RADIUS_BITS'(1));
		step_circle(2);
		start_circle(COORD_BITS'(1023), COORD_BITS'(-1024), RADIUS_BITS'(1023));
		step_circle(3);
		start_circle(COORD_BITS'(-1), COORD_BITS'(-1), RADIUS_BITS'(5));
		step_circle(5);
		start_circle(COORD_BITS'(100), COORD_BITS'(-200), RADIUS_BITS'(10));
		step_circle(2);
		start_circle(COORD_BITS'(-1024), COORD_BITS'(-1024), RADIUS_BITS'(2));
		step_circle(2);
		start_circle(COORD_BITS'(1023), COORD_BITS'(1023), RADIUS_BITS'(1023));
		step_circle(1);
		drain_points();

		while (reqs_sent < ITEM_GOAL) begin
			calm = (reqs_sent >= CALM_AFTER);
			gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			sel = $urandom_range(0, 19);
			if (sel < 16)
				r = RADIUS_BITS'($urandom_range(0, 24));
			else if (sel < 19)
				r = RADIUS_BITS'($urandom_range(0, 1023));
			else
				r = RADIUS_BITS'($urandom_range(1000, 1023));
			if (r > 24)
				n = $urandom_range(0, 8);
			else
				n = (int'(r) * 3) / 4 + 1;
			// broken sequences: cut short
			if ($urandom_range(0, 6) == 0)
				n = $urandom_range(0, n);
			start_circle(pick_center(), pick_center(), r);
			step_circle(n);
			if ($urandom_range(0, 14) == 0)
				drain_points();
		end

		req_valid = 1'b0;
		while (points_due != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
